FILE: rtl/rpd_pkg.sv
`default_nettype none

package rpd_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned EntryW = 6;
  localparam int unsigned SizeW  = 6;

  localparam logic [SizeW-1:0] ListSizeReset = 6'd32;

endpackage

`default_nettype wire

FILE: rtl/rpd_mod.sv
`default_nettype none

module rpd_mod #(
  parameter int unsigned CntW = 6
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [rpd_pkg::WordW-1:0] word_i,
  input  wire logic [CntW-1:0]          divisor_i,
  output logic                          done_o,
  output logic [CntW-1:0]               rem_o
);
  import rpd_pkg::*;

  localparam int unsigned BitW = $clog2(WordW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [BitW-1:0] bit_q, bit_d;
  logic [WordW-1:0] word_q, word_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW:0]   trial;

  always_comb begin
    trial  = {rem_q, word_q[WordW-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    word_d = word_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = BitW'(WordW - 1);
      word_d = word_i;
      rem_d  = '0;
    end else if (busy_q) begin
      word_d = {word_q[WordW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = CntW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[CntW-1:0];
      end
      bit_d = bit_q - BitW'(1);
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/random_permutation_draw.sv
`default_nettype none

// Draws a random permutation of 1..N one value per beat by the strike-out shuffle. Each input
// beat carries a random word; its remainder modulo the count of values left picks a position
// in an ascending store of the remaining values, that value is returned and removed, and
// last_draw marks the beat that empties the store. A draw runs through the accept, the
// bit-serial remainder unit (one bit of the word per cycle), a read of the chosen entry, a
// shift of the S entries above the chosen position, which move down one per cycle through
// the store memory, reading one entry while writing the one below it (S is at most N - 1),
// and a finish step; a permutation's first draw also refills the store one entry a cycle.
// A new list_size takes effect at the next refill; 0 is treated as 1 and values above
// MAX_ITEMS saturate.
module random_permutation_draw #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rpd_pkg::SizeW-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [rpd_pkg::WordW-1:0]   random_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rpd_pkg::EntryW-1:0]       drawn_value_o,
  output logic                             last_draw_o
);
  import rpd_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CmpW  = (CntW > SizeW) ? CntW : SizeW;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDiv    = 3'd1;
  localparam logic [2:0] StFill   = 3'd2;
  localparam logic [2:0] StRead   = 3'd3;
  localparam logic [2:0] StGrab   = 3'd4;
  localparam logic [2:0] StShift  = 3'd5;
  localparam logic [2:0] StFinish = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [SizeW-1:0]  list_size_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              fill_q, fill_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [EntryW-1:0] val_q, val_d;
  logic              out_valid_q, out_valid_d;
  logic [EntryW-1:0] drawn_q, drawn_d;
  logic              last_q, last_d;

  logic              in_accept;
  logic              div_done;
  logic [CntW-1:0]   div_rem;
  logic [AddrW-1:0]  pos;
  logic [CmpW-1:0]   size_ext;
  logic [CntW-1:0]   eff_size;
  logic [CntW-1:0]   idx_p1;
  logic [CntW-1:0]   idx_p2;
  logic [CntW-1:0]   pos_p1;
  logic              out_free;

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic [EntryW-1:0] wr_data, rd_data_q;
  logic [EntryW-1:0] store_mem [MAX_ITEMS];

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;
  assign pos        = div_rem[AddrW-1:0];
  assign idx_p1     = CntW'(idx_q) + CntW'(1);
  assign idx_p2     = CntW'(idx_q) + CntW'(2);
  assign pos_p1     = CntW'(pos) + CntW'(1);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    size_ext = CmpW'(list_size_q);
    if (size_ext == '0) begin
      eff_size = CntW'(1);
    end else if (size_ext > CmpW'(MAX_ITEMS)) begin
      eff_size = CntW'(MAX_ITEMS);
    end else begin
      eff_size = CntW'(size_ext);
    end
  end

  rpd_mod #(
    .CntW(CntW)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .word_i   (random_word_i),
    .divisor_i(count_q),
    .done_o   (div_done),
    .rem_o    (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    drawn_d     = drawn_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wr_addr     = idx_q;
    wr_data     = rd_data_q;
    rd_addr     = pos;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          fill_d  = (count_q == '0);
          count_d = (count_q == '0) ? eff_size : count_q;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          idx_d   = '0;
          state_d = fill_q ? StFill : StRead;
        end
      end
      StFill: begin
        mem_we  = 1'b1;
        wr_data = EntryW'(idx_p1);
        if (idx_p1 == count_q) begin
          state_d = StRead;
        end else begin
          idx_d = AddrW'(idx_p1);
        end
      end
      StRead: begin
        mem_re  = 1'b1;
        state_d = StGrab;
      end
      StGrab: begin
        val_d = rd_data_q;
        idx_d = pos;
        if (pos_p1 < count_q) begin
          mem_re  = 1'b1;
          rd_addr = AddrW'(pos_p1);
          state_d = StShift;
        end else begin
          state_d = StFinish;
        end
      end
      StShift: begin
        mem_we = 1'b1;
        idx_d  = AddrW'(idx_p1);
        if (idx_p2 < count_q) begin
          mem_re  = 1'b1;
          rd_addr = AddrW'(idx_p2);
        end else begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          drawn_d     = val_q;
          last_d      = (count_q == CntW'(1));
          count_d     = count_q - CntW'(1);
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      list_size_q <= ListSizeReset;
      count_q     <= '0;
      fill_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        list_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    val_q   <= val_d;
    drawn_q <= drawn_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drawn_value_o = drawn_q;
  assign last_draw_o   = last_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ITEMS))
    else $error("remaining count exceeds the store depth");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (count_q != '0))
    else $error("remainder taken with a zero divisor");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("remainder unit finished outside the divide phase");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift) |-> (idx_p1 < count_q))
    else $error("shift moves an entry beyond the remaining count");
`endif

endmodule

`default_nettype wire

FILE: dv/draw_checker.sv
`default_nettype none

module draw_checker #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rpd_pkg::SizeW-1:0]  cfg_wdata_i,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic [rpd_pkg::WordW-1:0]  random_word_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic [rpd_pkg::EntryW-1:0] drawn_value_i,
  input  wire logic                       last_draw_i,
  output int                              pending_o,
  output int                              fail_count_o,
  output int                              draw_count_o,
  output int                              perm_count_o
);
  import rpd_pkg::*;

  typedef struct packed {
    logic [EntryW-1:0] value;
    logic              last;
  } draw_t;

  logic [SizeW-1:0]  list_size;
  logic [EntryW-1:0] values_left [MAX_ITEMS];
  int unsigned       left_count;
  draw_t             expected_draws [$];
  int                fail_count;
  int                draw_count;
  int                perm_count;

  function automatic draw_t predict_draw(input logic [WordW-1:0] word);
    int unsigned n;
    int unsigned pos;
    draw_t       d;
    if (left_count == 0) begin
      n = (list_size == 0) ? 1 : ((list_size > MAX_ITEMS) ? MAX_ITEMS : list_size);
      for (int unsigned i = 0; i < n; i++) begin
        values_left[i] = EntryW'(i + 1);
      end
      left_count = n;
    end
    pos = word % left_count;
    d.value = values_left[pos];
    for (int unsigned i = pos; i + 1 < left_count; i++) begin
      values_left[i] = values_left[i + 1];
    end
    left_count--;
    d.last = (left_count == 0);
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    draw_t exp_draw;
    if (!rst_ni) begin
      list_size  = ListSizeReset;
      left_count = 0;
      expected_draws.delete();
      fail_count = 0;
      draw_count = 0;
      perm_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_draws.size() == 0) begin
          $error("Result beat with no draw outstanding: drawn_value %0d, last_draw %0b",
                 drawn_value_i, last_draw_i);
          fail_count++;
        end else begin
          exp_draw = expected_draws.pop_front();
          draw_count++;
          if (exp_draw.last) perm_count++;
          if (drawn_value_i !== exp_draw.value) begin
            $error("drawn_value: expected %0d, actual %0d", exp_draw.value, drawn_value_i);
            fail_count++;
          end
          if (last_draw_i !== exp_draw.last) begin
            $error("last_draw: expected %0b, actual %0b", exp_draw.last, last_draw_i);
            fail_count++;
          end
        end
      end
      if (cfg_we_i) list_size = cfg_wdata_i;
      if (in_valid_i && in_ready_i) expected_draws.push_back(predict_draw(random_word_i));
    end
    pending_o    <= expected_draws.size();
    fail_count_o <= fail_count;
    draw_count_o <= draw_count;
    perm_count_o <= perm_count;
  end

endmodule

`default_nettype wire

FILE: dv/tb_random_permutation_draw.sv
`default_nettype none

module tb_random_permutation_draw;
  import rpd_pkg::*;

  localparam int unsigned MaxItems    = 32;
  localparam int unsigned TargetWords = 1400;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned CycleLimit  = 1000000;

  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SizeW-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [WordW-1:0]  random_word_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [EntryW-1:0] drawn_value_o;
  logic              last_draw_o;

  int          pending;
  int          fail_count;
  int          draw_count;
  int          perm_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned words_sent;
  int unsigned size_writes;
  int unsigned cycles;

  random_permutation_draw #(
    .MAX_ITEMS(MaxItems)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .random_word_i(random_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drawn_value_o(drawn_value_o),
    .last_draw_o  (last_draw_o)
  );

  draw_checker #(
    .MAX_ITEMS(MaxItems)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .random_word_i(random_word_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drawn_value_i(drawn_value_o),
    .last_draw_i  (last_draw_o),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .draw_count_o (draw_count),
    .perm_count_o (perm_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d draws outstanding.", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= stall_pct);
  end

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IdleNone: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IdleSender: begin
        send_idle_pct = 67;
        stall_pct     = 0;
      end
      IdleReceiver: begin
        send_idle_pct = 0;
        stall_pct     = 67;
      end
      default: begin
        send_idle_pct = 15;
        stall_pct     = 15;
      end
    endcase
  endtask

  task automatic write_list_size(input logic [SizeW-1:0] size);
    while (pending != 0) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = size;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    size_writes++;
  endtask

  task automatic send_word(input logic [WordW-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    random_word_i = word;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    words_sent++;
  endtask

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return WordW'($urandom_range(63));
      default: return WordW'($urandom());
    endcase
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    case ($urandom_range(9))
      0: return '0;
      1: return SizeW'(1);
      2: return SizeW'(2);
      3: return SizeW'(MaxItems);
      4: return SizeW'(MaxItems + 1);
      5: return '1;
      default: return SizeW'($urandom_range(63));
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned batch;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    random_word_i = '0;
    words_sent    = 0;
    size_writes   = 0;
    set_idle_mode(IdleNone);
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // A size of one draws 1 every time, and zero must behave the same way.
    write_list_size(SizeW'(1));
    send_word('1);
    send_word('0);
    write_list_size('0);
    send_word('1);
    send_word(WordW'(16'h5555));

    // A size change in the middle of a permutation waits for the next refill.
    write_list_size(SizeW'(3));
    send_word('1);
    write_list_size('1);
    send_word(WordW'(16'hAAAA));
    send_word('0);
    send_word('1);
    send_word(WordW'(16'h8000));
    send_word(WordW'(31));
    write_list_size(SizeW'(MaxItems + 1));
    send_word(WordW'(16'h7FFF));
    send_word('0);
    write_list_size(SizeW'(MaxItems));
    send_word(WordW'(16'h0001));

    phase = 0;
    while (words_sent < TargetWords) begin
      set_idle_mode(idle_mode_e'(phase % 4));
      write_list_size(pick_size());
      batch = $urandom_range(30, 90);
      repeat (batch) send_word(pick_word());
      phase++;
    end

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Drew %0d values from %0d random words, completing %0d permutations.",
             draw_count, words_sent, perm_count);
    $display("List size was written %0d times over %0d random phases of varied idling.",
             size_writes, phase);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
